// ===== hdl/ffra_pkg.sv =====
// Shared types, codes and defaults for the first-fit range allocator.
package ffra_pkg;

  localparam int MAX_HOLES_DEF = 64;

  typedef enum logic [1:0] {
    CMD_ALLOC  = 2'd0,
    CMD_FREE   = 2'd1,
    CMD_GROW   = 2'd2,
    CMD_REINIT = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_NO_FIT       = 3'd1,
    ST_FREE_REFUSED = 3'd2,
    ST_GROW_REFUSED = 3'd3,
    ST_TABLE_FULL   = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_ALLOC_TRIM,
    ACT_ALLOC_REMOVE,
    ACT_FREE_BOTH,
    ACT_FREE_LEFT,
    ACT_FREE_RIGHT,
    ACT_FREE_INSERT,
    ACT_GROW_EXTEND,
    ACT_GROW_APPEND,
    ACT_REINIT
  } act_t;

  // broadcast from the sequencer to every cell
  typedef struct packed {
    logic        apply;
    act_t        act;
    cmd_t        cmd;
    logic [31:0] s;
    logic [31:0] n;
    logic [31:0] aux;   // grow: added space, reinit: new capacity
    logic [31:0] cap;   // capacity before the command
  } ctl_t;

  // what a cell shows its neighbors
  typedef struct packed {
    logic [31:0] start;
    logic [31:0] len;
    logic        lt;        // occupied and start below ctl.s
    logic        boundary;  // insertion point of a free
  } nb_t;

  // word handed down the chain, one cell per cycle
  typedef struct packed {
    logic        found;
    logic        a;
    logic        b;
    logic [31:0] value;
    logic [31:0] sum;
    logic [31:0] max;
  } chain_t;

endpackage

// ===== hdl/ffra_cell.sv =====
// One table cell: holds a hole and passes search and statistics words on.
module ffra_cell import ffra_pkg::*; #(
  parameter int N   = MAX_HOLES_DEF,
  parameter int IDX = 0,
  parameter int CW  = $clog2(N + 1)
) (
  input  logic          clk,
  input  ctl_t          ctl,
  input  logic [CW-1:0] count,
  input  nb_t           left_nb,
  input  chain_t        left_ch,
  input  nb_t           right_nb,
  output nb_t           nb,
  output chain_t        ch
);

  logic [31:0] start;
  logic [31:0] len;
  logic occ, occ_l, occ_r, lt, boundary;
  logic hit, ha, hb, cin, first, rfirst;

  assign occ   = CW'(IDX) < count;
  assign occ_r = CW'(IDX + 1) < count;
  assign occ_l = (IDX != 0) && (CW'(IDX) <= count);
  assign lt    = occ && (start < ctl.s);
  assign boundary = ((IDX == 0) || left_nb.lt) && !lt;

  assign nb.start    = start;
  assign nb.len      = len;
  assign nb.lt       = lt;
  assign nb.boundary = boundary;

  always_comb begin
    hit = 1'b0;
    ha  = 1'b0;
    hb  = 1'b0;
    case (ctl.cmd)
      CMD_ALLOC: begin
        hit = occ && (len >= ctl.n);
        ha  = (len == ctl.n);
      end
      CMD_FREE: begin
        hit = boundary;
        ha  = occ_l && (left_nb.start + left_nb.len == ctl.s);
        hb  = occ && (ctl.s + ctl.n == start);
      end
      CMD_GROW: begin
        hit = occ && !occ_r;
        ha  = (start + len == ctl.cap);
      end
      default: ;
    endcase
  end

  assign cin   = left_ch.found;
  assign first = hit && !cin;
  // right neighbor is the insertion point only if nothing matched up to here
  assign rfirst = right_nb.boundary && !ch.found;

  always_ff @(posedge clk) begin
    if (cin) begin
      ch.found <= 1'b1;
      ch.a     <= left_ch.a;
      ch.b     <= left_ch.b;
      ch.value <= left_ch.value;
    end else begin
      ch.found <= hit;
      ch.a     <= ha;
      ch.b     <= hb;
      ch.value <= start;
    end
    ch.sum <= left_ch.sum + (occ ? len : 32'd0);
    ch.max <= (occ && (len > left_ch.max)) ? len : left_ch.max;
  end

  always_ff @(posedge clk) begin
    if (ctl.apply) begin
      case (ctl.act)
        ACT_ALLOC_TRIM: begin
          if (first) begin
            start <= start + ctl.n;
            len   <= len - ctl.n;
          end
        end
        ACT_ALLOC_REMOVE: begin
          if (first || cin) begin
            start <= right_nb.start;
            len   <= right_nb.len;
          end
        end
        ACT_FREE_BOTH: begin
          if (rfirst) begin
            len <= len + ctl.n + right_nb.len;
          end else if (first || cin) begin
            start <= right_nb.start;
            len   <= right_nb.len;
          end
        end
        ACT_FREE_LEFT: begin
          if (rfirst) len <= len + ctl.n;
        end
        ACT_FREE_RIGHT: begin
          if (first) begin
            start <= ctl.s;
            len   <= len + ctl.n;
          end
        end
        ACT_FREE_INSERT: begin
          if (first) begin
            start <= ctl.s;
            len   <= ctl.n;
          end else if (cin) begin
            start <= left_nb.start;
            len   <= left_nb.len;
          end
        end
        ACT_GROW_EXTEND: begin
          if (occ && !occ_r) len <= len + ctl.aux;
        end
        ACT_GROW_APPEND: begin
          if (!occ && ((IDX == 0) || occ_l)) begin
            start <= ctl.cap;
            len   <= ctl.aux;
          end
        end
        ACT_REINIT: begin
          if (IDX == 0) begin
            start <= 32'd0;
            len   <= ctl.aux;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/first_fit_range_allocator_unit.sv =====
// First-fit range allocator: hole table as a chain of cells plus sequencer.
//
// Input channel: in_valid / in_stall with command, range_start, range_length
// and new_capacity. Output channel: out_valid / out_stall with offset,
// status, free_total and largest_hole. One result word per command.
// A word is taken when valid is high and stall is low.
//
// For each command, the first-fit / insertion search ripples one cell per
// cycle down the chain, then the update is applied in all cells at once,
// and the free-space sum and largest hole ripple down again and land in the
// output register.
// One command is in flight at a time; in_stall is high while it works.
//
// The result sits in an output register. A new command is accepted while
// that result waits; its result is held back until the old one is taken.
//
// Reset empties the table and sets the capacity to zero; no clearing pass.
module first_fit_range_allocator_unit import ffra_pkg::*; #(
  parameter int MAX_HOLES = MAX_HOLES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command,
  input  logic [31:0] range_start,
  input  logic [31:0] range_length,
  input  logic [31:0] new_capacity,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] offset,
  output logic [2:0]  status,
  output logic [31:0] free_total,
  output logic [31:0] largest_hole
);

  localparam int N    = MAX_HOLES;
  localparam int CW   = $clog2(N + 1);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_APPLY  = 4'b0100,
    S_SETTLE = 4'b1000
  } state_t;

  state_t        state;
  logic [CW-1:0] cnt;
  cmd_t          cmd_q;
  logic [31:0]   s_q, n_q, nc_q;
  logic [31:0]   cap, cap_next;
  logic [CW-1:0] count, count_next;
  logic [31:0]   off_q, off_c;
  status_t       st_q, st_c;
  act_t          act;
  ctl_t          ctl;

  nb_t    nb [N];
  chain_t ch [N];
  nb_t    nb_zero, nb_end;
  chain_t ch_zero;

  assign nb_zero = '0;
  assign ch_zero = '0;
  always_comb begin
    nb_end          = '0;
    nb_end.boundary = nb[N-1].lt;
  end

  for (genvar k = 0; k < N; k++) begin : g_cell
    ffra_cell #(.N(N), .IDX(k), .CW(CW)) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .count    (count),
      .left_nb  ((k == 0) ? nb_zero : nb[(k == 0) ? 0 : k - 1]),
      .left_ch  ((k == 0) ? ch_zero : ch[(k == 0) ? 0 : k - 1]),
      .right_nb ((k == N - 1) ? nb_end : nb[(k == N - 1) ? k : k + 1]),
      .nb       (nb[k]),
      .ch       (ch[k])
    );
  end

  always_comb begin
    ctl.apply = (state == S_APPLY);
    ctl.act   = act;
    ctl.cmd   = cmd_q;
    ctl.s     = s_q;
    ctl.n     = n_q;
    ctl.aux   = (cmd_q == CMD_REINIT) ? nc_q : nc_q - cap;
    ctl.cap   = cap;
  end

  // decision from the settled end of the chain
  logic fnd, fa, fb, left_m, right_m, full, ltop;
  assign fnd  = ch[N-1].found;
  assign fa   = ch[N-1].a;
  assign fb   = ch[N-1].b;
  assign full = (count == CW'(N));
  // insertion past the last cell: left merge with the last hole only
  assign ltop = full && (nb[N-1].start + nb[N-1].len == s_q);
  assign left_m  = fnd ? fa : ltop;
  assign right_m = fnd && fb;

  always_comb begin
    act        = ACT_NONE;
    st_c       = ST_OK;
    off_c      = 32'd0;
    count_next = count;
    cap_next   = cap;
    case (cmd_q)
      CMD_ALLOC: begin
        if (n_q == 32'd0) begin
          off_c = fnd ? ch[N-1].value : 32'd0;
        end else if (fnd) begin
          off_c = ch[N-1].value;
          if (fa) begin
            act        = ACT_ALLOC_REMOVE;
            count_next = count - CW'(1);
          end else begin
            act = ACT_ALLOC_TRIM;
          end
        end else begin
          st_c  = ST_NO_FIT;
          off_c = '1;
        end
      end
      CMD_FREE: begin
        if (n_q != 32'd0) begin
          if (s_q >= cap || n_q > cap - s_q) begin
            st_c = ST_FREE_REFUSED;
          end else if (left_m && right_m) begin
            act        = ACT_FREE_BOTH;
            count_next = count - CW'(1);
          end else if (left_m) begin
            act = ACT_FREE_LEFT;
          end else if (right_m) begin
            act = ACT_FREE_RIGHT;
          end else if (full) begin
            st_c = ST_TABLE_FULL;
          end else begin
            act        = ACT_FREE_INSERT;
            count_next = count + CW'(1);
          end
        end
      end
      CMD_GROW: begin
        if (nc_q <= cap) begin
          st_c = ST_GROW_REFUSED;
        end else if (fnd && fa) begin
          act      = ACT_GROW_EXTEND;
          cap_next = nc_q;
        end else if (full) begin
          st_c = ST_TABLE_FULL;
        end else begin
          act        = ACT_GROW_APPEND;
          count_next = count + CW'(1);
          cap_next   = nc_q;
        end
      end
      default: begin
        act        = ACT_REINIT;
        cap_next   = nc_q;
        count_next = (nc_q != 32'd0) ? CW'(1) : CW'(0);
      end
    endcase
  end

  assign in_stall = (state != S_IDLE);

  // result word moves into the output register this cycle
  logic issue;
  assign issue = (state == S_SETTLE) && (cnt == CW'(N)) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      count     <= '0;
      cap       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (issue) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd_q <= cmd_t'(command);
            s_q   <= range_start;
            n_q   <= range_length;
            nc_q  <= new_capacity;
            cnt   <= '0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (cnt == CW'(N - 1)) state <= S_APPLY;
          else cnt <= cnt + CW'(1);
        end
        S_APPLY: begin
          count <= count_next;
          cap   <= cap_next;
          st_q  <= st_c;
          off_q <= off_c;
          cnt   <= '0;
          state <= S_SETTLE;
        end
        S_SETTLE: begin
          if (cnt != CW'(N)) begin
            cnt <= cnt + CW'(1);
          end else if (issue) begin
            offset       <= off_q;
            status       <= st_q;
            free_total   <= ch[N-1].sum;
            largest_hole <= ch[N-1].max;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(N)) else $error("hole count above table size");

  a_insert_inc: assert property (@(posedge clk) disable iff (rst)
    (state == S_APPLY) && (act == ACT_FREE_INSERT || act == ACT_GROW_APPEND)
      |=> count == $past(count) + CW'(1)) else $error("insert did not add a hole");

  a_remove_dec: assert property (@(posedge clk) disable iff (rst)
    (state == S_APPLY) && (act == ACT_ALLOC_REMOVE || act == ACT_FREE_BOTH)
      |=> count == $past(count) - CW'(1)) else $error("remove did not drop a hole");

  a_result_once: assert property (@(posedge clk) disable iff (rst)
    (state == S_SETTLE) && out_valid && out_stall |=> state != S_IDLE)
    else $error("result issued over a waiting word");

endmodule

// ===== sim/tb_first_fit_range_allocator_unit.sv =====
// Testbench for the first-fit range allocator: random and directed commands, scoreboard check.
`timescale 1ns / 100ps

module tb_first_fit_range_allocator_unit;
  import ffra_pkg::*;

  localparam int HOLES = MAX_HOLES_DEF;
  localparam int LATENCY = 2 * HOLES + 2;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    logic [31:0] offset;
    status_t     status;
    logic [31:0] free_total;
    logic [31:0] largest_hole;
  } alloc_word_t;

  // predictor of the hole table plus queue of expected words
  class hole_table_scoreboard;
    logic [31:0] starts[HOLES];
    logic [31:0] lens[HOLES];
    int unsigned count;
    logic [31:0] capacity;
    alloc_word_t pending[$];
    int errors;

    function new();
      count = 0;
      capacity = 0;
      errors = 0;
    endfunction

    function void drop(int unsigned i);
      for (int unsigned k = i; k + 1 < count; k++) begin
        starts[k] = starts[k + 1];
        lens[k] = lens[k + 1];
      end
      count--;
    endfunction

    function void note_command(cmd_t cmd, logic [31:0] rs, logic [31:0] rl,
                               logic [31:0] nc);
      alloc_word_t w;
      int unsigned i;
      bit done, lft, rgt;
      w.offset = 0;
      w.status = ST_OK;
      case (cmd)
        CMD_ALLOC: begin
          if (rl == 0) begin
            w.offset = count ? starts[0] : 32'd0;
          end else begin
            done = 0;
            for (i = 0; i < count && !done; i++) begin
              if (lens[i] >= rl) begin
                w.offset = starts[i];
                if (lens[i] == rl) drop(i);
                else begin
                  starts[i] = starts[i] + rl;
                  lens[i] = lens[i] - rl;
                end
                done = 1;
              end
            end
            if (!done) begin
              w.status = ST_NO_FIT;
              w.offset = '1;
            end
          end
        end
        CMD_FREE: begin
          if (rl == 0) begin
          end else if (rs >= capacity || rl > capacity - rs) begin
            w.status = ST_FREE_REFUSED;
          end else begin
            i = 0;
            while (i < count && starts[i] < rs) i++;
            rgt = (i < count) && (rs + rl == starts[i]);
            lft = (i > 0) && (starts[i - 1] + lens[i - 1] == rs);
            if (lft && rgt) begin
              lens[i - 1] = lens[i - 1] + rl + lens[i];
              drop(i);
            end else if (lft) begin
              lens[i - 1] = lens[i - 1] + rl;
            end else if (rgt) begin
              starts[i] = rs;
              lens[i] = lens[i] + rl;
            end else if (count >= HOLES) begin
              w.status = ST_TABLE_FULL;
            end else begin
              for (int unsigned k = count; k > i; k--) begin
                starts[k] = starts[k - 1];
                lens[k] = lens[k - 1];
              end
              starts[i] = rs;
              lens[i] = rl;
              count++;
            end
          end
        end
        CMD_GROW: begin
          if (nc <= capacity) begin
            w.status = ST_GROW_REFUSED;
          end else if (count > 0 && starts[count - 1] + lens[count - 1] == capacity) begin
            lens[count - 1] = lens[count - 1] + (nc - capacity);
            capacity = nc;
          end else if (count >= HOLES) begin
            w.status = ST_TABLE_FULL;
          end else begin
            starts[count] = capacity;
            lens[count] = nc - capacity;
            count++;
            capacity = nc;
          end
        end
        default: begin
          capacity = nc;
          count = 0;
          if (nc > 0) begin
            starts[0] = 0;
            lens[0] = nc;
            count = 1;
          end
        end
      endcase
      w.free_total = 0;
      w.largest_hole = 0;
      for (i = 0; i < count; i++) begin
        w.free_total = w.free_total + lens[i];
        if (lens[i] > w.largest_hole) w.largest_hole = lens[i];
      end
      pending.insert(pending.size(), w);
    endfunction

    function void check_word(alloc_word_t got);
      alloc_word_t exp;
      if (pending.size() == 0) begin
        $error("unexpected result word offset=%h", got.offset);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.offset !== exp.offset) begin
        $error("offset exp %h got %h", exp.offset, got.offset); errors++;
      end
      if (got.status !== exp.status) begin
        $error("status exp %0d got %0d", exp.status, got.status); errors++;
      end
      if (got.free_total !== exp.free_total) begin
        $error("free_total exp %h got %h", exp.free_total, got.free_total); errors++;
      end
      if (got.largest_hole !== exp.largest_hole) begin
        $error("largest_hole exp %h got %h", exp.largest_hole, got.largest_hole); errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic [1:0] command = 0;
  logic [31:0] range_start = 0, range_length = 0, new_capacity = 0;
  logic out_valid;
  logic out_stall = 0;
  logic [31:0] offset, free_total, largest_hole;
  logic [2:0] status;

  hole_table_scoreboard sb = new();
  bit calm = 0;          // no idling on either side
  int idle_cycles = 0;
  logic [31:0] cap_now = 0;

  first_fit_range_allocator_unit uut (.*);

  always #10 clk = ~clk;

  always @(posedge clk) begin
    alloc_word_t w;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        w.offset = offset;
        w.status = status_t'(status);
        w.free_total = free_total;
        w.largest_hole = largest_hole;
        sb.check_word(w);
      end
      out_stall <= calm ? 1'b0 : ($urandom_range(99) < 30);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // valid stays up after an accept unless the next word is preceded by idling
  task automatic send_cmd(cmd_t c, logic [31:0] rs, logic [31:0] rl, logic [31:0] nc);
    if (!calm && $urandom_range(99) < 30) begin
      in_valid <= 0;
      do @(posedge clk); while ($urandom_range(99) < 30);
    end
    in_valid <= 1;
    command <= c;
    range_start <= rs;
    range_length <= rl;
    new_capacity <= nc;
    do @(posedge clk); while (in_stall);
    sb.note_command(c, rs, rl, nc);
    if (c == CMD_REINIT || (c == CMD_GROW && nc > cap_now)) cap_now = sb.capacity;
  endtask

  // mostly allocs and in-range frees of modest size within the capacity
  task automatic send_random;
    int unsigned r;
    logic [31:0] s, n;
    r = $urandom_range(99);
    if (r < 35) begin
      n = ($urandom_range(9) == 0) ? $urandom() : $urandom_range(64);
      send_cmd(CMD_ALLOC, $urandom(), n, $urandom());
    end else if (r < 75) begin
      if (cap_now != 0 && $urandom_range(9) != 0) begin
        s = $urandom_range(cap_now - 1);
        n = $urandom_range(((cap_now - s) > 40) ? 40 : (cap_now - s));
      end else begin
        s = $urandom();
        n = $urandom();
      end
      send_cmd(CMD_FREE, s, n, $urandom());
    end else if (r < 90) begin
      n = ($urandom_range(4) == 0) ? $urandom() : sb.capacity + $urandom_range(64);
      send_cmd(CMD_GROW, $urandom(), $urandom(), n);
    end else begin
      n = ($urandom_range(5) == 0) ? $urandom() : $urandom_range(600);
      send_cmd(CMD_REINIT, $urandom(), $urandom(), n);
    end
    cap_now = sb.capacity;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // empty table, zero capacity
    send_cmd(CMD_ALLOC, 0, 0, 0);
    send_cmd(CMD_ALLOC, 0, 1, 0);
    send_cmd(CMD_FREE, 0, 1, 0);
    send_cmd(CMD_GROW, 0, 0, 0);
    send_cmd(CMD_GROW, 0, 0, 100);
    send_cmd(CMD_ALLOC, 0, 100, 0);
    send_cmd(CMD_GROW, 0, 0, 200);
    send_cmd(CMD_ALLOC, 0, 10, 0);
    send_cmd(CMD_ALLOC, 0, 0, 0);
    send_cmd(CMD_FREE, 50, 0, 0);
    send_cmd(CMD_FREE, 50, 10, 0);
    send_cmd(CMD_FREE, 0, 50, 0);      // merges with right neighbor
    send_cmd(CMD_FREE, 60, 40, 0);     // merges with left neighbor
    send_cmd(CMD_FREE, 300, 1, 0);     // out of buffer
    send_cmd(CMD_FREE, 150, 60, 0);    // runs past the end
    send_cmd(CMD_FREE, 10, 20, 0);     // overlapping
    send_cmd(CMD_REINIT, 0, 0, 32'hFFFF_FFFF);
    send_cmd(CMD_ALLOC, 0, 32'hFFFF_FFFF, 0);
    send_cmd(CMD_FREE, 32'hFFFF_FFFE, 1, 0);
    send_cmd(CMD_GROW, 0, 0, 32'hFFFF_FFFF);
    send_cmd(CMD_REINIT, 0, 0, 0);
    // fill the table with isolated holes, then overflow it
    send_cmd(CMD_REINIT, 0, 0, 2 * HOLES + 10);
    send_cmd(CMD_ALLOC, 0, 2 * HOLES + 10, 0);
    for (int i = 0; i < HOLES + 1; i++) send_cmd(CMD_FREE, 2 * i, 1, 0);
    send_cmd(CMD_GROW, 0, 0, 2 * HOLES + 20);
    send_cmd(CMD_GROW, 0, 0, 2 * HOLES + 20);
    cap_now = sb.capacity;
    for (int i = 0; i < 1750; i++) begin
      calm = (i >= 600 && i < 900);
      send_random();
    end
    in_valid <= 0;
    calm = 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
